[rtl/gtss_pkg.sv]
`timescale 1ns / 1ps

package gtss_pkg;

   localparam int VALUE_WIDTH   = 17;
   localparam int TICK_WIDTH    = 16;
   localparam int SPEED_WIDTH   = 8;
   localparam int SEG_WIDTH     = 8;
   localparam int DIGIT_COUNT   = 5;
   localparam int BCD_DIGITS    = 6;
   localparam int DABBLE_WIDTH  = 4 * BCD_DIGITS + VALUE_WIDTH;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [TICK_WIDTH-1:0]  GATE_RESET  = 16'd12287;
   localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 8'd5;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_RESET = 17'd99999;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_GATE_TICKS_MINUS_ONE = 2'd0,
      CSR_SPEED_PER_PULSE      = 2'd1,
      CSR_DISPLAY_LIMIT        = 2'd2
   } csr_index_type;

   typedef logic [SEG_WIDTH-1:0]    seg_type;
   typedef logic [DABBLE_WIDTH-1:0] dabble_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   clamped;
   } result_type;

   function automatic seg_type seg_code(logic [3:0] digit);
      seg_type code;
      case (digit)
         4'd0:    code = 8'hFC;
         4'd1:    code = 8'h60;
         4'd2:    code = 8'hDB;
         4'd3:    code = 8'hF3;
         4'd4:    code = 8'h67;
         4'd5:    code = 8'hB7;
         4'd6:    code = 8'hBF;
         4'd7:    code = 8'hE4;
         4'd8:    code = 8'hFF;
         4'd9:    code = 8'hF7;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // one shift-add-3 step of the binary to bcd conversion
   function automatic dabble_type dabble_step(dabble_type x);
      dabble_type y;
      logic [3:0] nib;
      y = x;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         nib = y[VALUE_WIDTH + 4 * i +: 4];
         if (nib >= 4'd5) begin
            y[VALUE_WIDTH + 4 * i +: 4] = nib + 4'd3;
         end
      end
      return y << 1;
   endfunction

endpackage

[rtl/gtss_digits.sv]
`timescale 1ns / 1ps

module gtss_digits
   import gtss_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  result_type                     in_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [VALUE_WIDTH-1:0]         rsp_speed_value,
   output seg_type [DIGIT_COUNT-1:0]      rsp_seg,
   output logic                           rsp_clamped
);

   localparam int A_STEPS = 6;
   localparam int B_STEPS = 6;
   localparam int C_STEPS = VALUE_WIDTH - A_STEPS - B_STEPS;

   logic                         a_valid_ff, a_valid_in;
   dabble_type                   a_work_ff, a_work_in;
   result_type                   a_data_ff, a_data_in;
   logic                         b_valid_ff, b_valid_in;
   dabble_type                   b_work_ff, b_work_in;
   result_type                   b_data_ff, b_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]       rsp_value_ff, rsp_value_in;
   seg_type [DIGIT_COUNT-1:0]    rsp_seg_ff, rsp_seg_in;
   logic                         rsp_clamped_ff, rsp_clamped_in;

   logic                         o_free, b_free, a_free;
   dabble_type                   a_calc, b_calc, c_calc;

   always_comb begin
      o_free = !rsp_valid_ff || !rsp_stall;
      b_free = !b_valid_ff || o_free;
      a_free = !a_valid_ff || b_free;
      in_stall = !a_free;
   end

   // conversion split over three stages
   always_comb begin
      a_calc = DABBLE_WIDTH'(in_data.value);
      for (int i = 0; i < A_STEPS; i++) begin
         a_calc = dabble_step(a_calc);
      end
      b_calc = a_work_ff;
      for (int i = 0; i < B_STEPS; i++) begin
         b_calc = dabble_step(b_calc);
      end
      c_calc = b_work_ff;
      for (int i = 0; i < C_STEPS; i++) begin
         c_calc = dabble_step(c_calc);
      end
   end

   always_comb begin
      a_valid_in     = a_valid_ff;
      a_work_in      = a_work_ff;
      a_data_in      = a_data_ff;
      b_valid_in     = b_valid_ff;
      b_work_in      = b_work_ff;
      b_data_in      = b_data_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_seg_in     = rsp_seg_ff;
      rsp_clamped_in = rsp_clamped_ff;
      if (a_free) begin
         a_valid_in = in_valid;
         a_work_in  = a_calc;
         a_data_in  = in_data;
      end
      if (b_free) begin
         b_valid_in = a_valid_ff;
         b_work_in  = b_calc;
         b_data_in  = a_data_ff;
      end
      if (o_free) begin
         rsp_valid_in   = b_valid_ff;
         rsp_value_in   = b_data_ff.value;
         rsp_clamped_in = b_data_ff.clamped;
         // low five bcd digits; a sixth one is dropped
         for (int k = 0; k < DIGIT_COUNT; k++) begin
            rsp_seg_in[k] = seg_code(c_calc[VALUE_WIDTH + 4 * k +: 4]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_work_ff      <= a_work_in;
      a_data_ff      <= a_data_in;
      b_work_ff      <= b_work_in;
      b_data_ff      <= b_data_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_seg_ff     <= rsp_seg_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_value = rsp_value_ff;
   assign rsp_seg         = rsp_seg_ff;
   assign rsp_clamped     = rsp_clamped_ff;

endmodule

[rtl/gated_tachometer_seven_segment_top.sv]
`timescale 1ns / 1ps

// Gated tachometer: takes one pulse/tick item per clock while req_stall is low and counts
// encoder pulses over a window of gate_ticks_minus_one + 1 timer ticks. The item that
// closes a window yields one result: the pulse count times speed_per_pulse, clamped to
// display_limit, with five seven-segment digit codes. After its closing item is taken, a
// result passes through the close register, multiplier, clamp compare and three binary to
// bcd stages. Those six stages hold up to six pending results, so req_stall rises only
// when all of them are full and the output is stalled.

module gated_tachometer_seven_segment_top
   import gtss_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_pulse_edge,
   input  logic                     req_time_tick,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [VALUE_WIDTH-1:0]   rsp_speed_value,
   output logic [SEG_WIDTH-1:0]     rsp_seg_digit_ten_thousands,
   output logic [SEG_WIDTH-1:0]     rsp_seg_digit_thousands,
   output logic [SEG_WIDTH-1:0]     rsp_seg_digit_hundreds,
   output logic [SEG_WIDTH-1:0]     rsp_seg_digit_tens,
   output logic [SEG_WIDTH-1:0]     rsp_seg_digit_ones,
   output logic                     rsp_clamped,
   input  logic                     csr_write,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [VALUE_WIDTH-1:0]   csr_wdata
);

   localparam int PRODUCT_WIDTH = COUNT_WIDTH + SPEED_WIDTH;
   localparam int CMP_WIDTH = (PRODUCT_WIDTH > VALUE_WIDTH) ? PRODUCT_WIDTH : VALUE_WIDTH;

   logic [TICK_WIDTH-1:0]    gate_ff, gate_in;
   logic [SPEED_WIDTH-1:0]   speed_ff, speed_in;
   logic [VALUE_WIDTH-1:0]   limit_ff, limit_in;

   logic [COUNT_WIDTH-1:0]   pulse_tally_ff, pulse_tally_in;
   logic [TICK_WIDTH-1:0]    tick_tally_ff, tick_tally_in;

   logic                     c_valid_ff, c_valid_in;
   logic [COUNT_WIDTH-1:0]   c_tally_ff, c_tally_in;
   logic                     p_valid_ff, p_valid_in;
   logic [PRODUCT_WIDTH-1:0] p_product_ff, p_product_in;
   logic                     v_valid_ff, v_valid_in;
   result_type               v_data_ff, v_data_in;

   logic                     accept, close;
   logic                     c_free, p_free, v_free;
   logic                     digits_stall;
   logic [COUNT_WIDTH-1:0]   tally_next;
   logic [CMP_WIDTH-1:0]     product_ext, limit_ext;
   seg_type [DIGIT_COUNT-1:0] seg;

   // configuration registers
   always_comb begin
      gate_in  = gate_ff;
      speed_in = speed_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_GATE_TICKS_MINUS_ONE: gate_in  = csr_wdata[TICK_WIDTH-1:0];
            CSR_SPEED_PER_PULSE:      speed_in = csr_wdata[SPEED_WIDTH-1:0];
            CSR_DISPLAY_LIMIT:        limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      v_free    = !v_valid_ff || !digits_stall;
      p_free    = !p_valid_ff || v_free;
      c_free    = !c_valid_ff || p_free;
      req_stall = !c_free;
      accept    = req_valid && c_free;
   end

   // window counting; a pulse in the closing item still counts
   always_comb begin
      tally_next = pulse_tally_ff;
      if (req_pulse_edge && (pulse_tally_ff != {COUNT_WIDTH{1'b1}})) begin
         tally_next = pulse_tally_ff + 1'b1;
      end
      close          = req_time_tick && (tick_tally_ff >= gate_ff);
      pulse_tally_in = pulse_tally_ff;
      tick_tally_in  = tick_tally_ff;
      if (accept) begin
         pulse_tally_in = tally_next;
         if (req_time_tick) begin
            if (close) begin
               pulse_tally_in = '0;
               tick_tally_in  = '0;
            end else begin
               tick_tally_in = tick_tally_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      c_valid_in   = c_valid_ff;
      c_tally_in   = c_tally_ff;
      p_valid_in   = p_valid_ff;
      p_product_in = p_product_ff;
      v_valid_in   = v_valid_ff;
      v_data_in    = v_data_ff;
      product_ext  = CMP_WIDTH'(p_product_ff);
      limit_ext    = CMP_WIDTH'(limit_ff);
      if (c_free) begin
         c_valid_in = accept && close;
         c_tally_in = tally_next;
      end
      if (p_free) begin
         p_valid_in   = c_valid_ff;
         p_product_in = PRODUCT_WIDTH'(c_tally_ff) * PRODUCT_WIDTH'(speed_ff);
      end
      if (v_free) begin
         v_valid_in        = p_valid_ff;
         v_data_in.clamped = product_ext > limit_ext;
         v_data_in.value   = (product_ext > limit_ext) ? limit_ff
                                                       : product_ext[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff        <= GATE_RESET;
         speed_ff       <= SPEED_RESET;
         limit_ff       <= LIMIT_RESET;
         pulse_tally_ff <= '0;
         tick_tally_ff  <= '0;
         c_valid_ff     <= 1'b0;
         p_valid_ff     <= 1'b0;
         v_valid_ff     <= 1'b0;
      end else begin
         gate_ff        <= gate_in;
         speed_ff       <= speed_in;
         limit_ff       <= limit_in;
         pulse_tally_ff <= pulse_tally_in;
         tick_tally_ff  <= tick_tally_in;
         c_valid_ff     <= c_valid_in;
         p_valid_ff     <= p_valid_in;
         v_valid_ff     <= v_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_tally_ff   <= c_tally_in;
      p_product_ff <= p_product_in;
      v_data_ff    <= v_data_in;
   end

   gtss_digits u_digits (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (v_valid_ff),
      .in_stall        (digits_stall),
      .in_data         (v_data_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_speed_value (rsp_speed_value),
      .rsp_seg         (seg),
      .rsp_clamped     (rsp_clamped)
   );

   assign rsp_seg_digit_ones          = seg[0];
   assign rsp_seg_digit_tens          = seg[1];
   assign rsp_seg_digit_hundreds      = seg[2];
   assign rsp_seg_digit_thousands     = seg[3];
   assign rsp_seg_digit_ten_thousands = seg[4];

endmodule

[rtl/gtss_checker.sv]
`timescale 1ns / 1ps

module gtss_checker
   import gtss_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [VALUE_WIDTH-1:0]   rsp_speed_value,
   input logic [SEG_WIDTH-1:0]     rsp_seg_digit_ten_thousands,
   input logic [SEG_WIDTH-1:0]     rsp_seg_digit_thousands,
   input logic [SEG_WIDTH-1:0]     rsp_seg_digit_hundreds,
   input logic [SEG_WIDTH-1:0]     rsp_seg_digit_tens,
   input logic [SEG_WIDTH-1:0]     rsp_seg_digit_ones,
   input logic                     rsp_clamped
);

   // the pipeline is cleared by reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // with the output free to move, no stage can be blocked
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output is free");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_speed_value)
                                    && $stable(rsp_clamped)
                                    && $stable(rsp_seg_digit_ones)))
      else $error("stalled result changed");

   // a zero speed shows zero on every digit
   a_zero_digits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speed_value == '0) |->
         (rsp_seg_digit_ones == seg_code(4'd0) && rsp_seg_digit_tens == seg_code(4'd0)
          && rsp_seg_digit_hundreds == seg_code(4'd0)
          && rsp_seg_digit_thousands == seg_code(4'd0)
          && rsp_seg_digit_ten_thousands == seg_code(4'd0)))
      else $error("zero speed with nonzero digit code");

endmodule

bind gated_tachometer_seven_segment_top gtss_checker u_checker (.*);
